// ----- rtl/core/brlb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlb_pkg
// Shared types and constants for the byte ring / linear buffer.
// ----------------------------------------------------------------------------
package brlb_pkg;

   localparam int DEPTH   = 1024;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = 11;
   localparam int DATA_W  = 8;
   localparam int OFF_W   = 10;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [CNT_W-1:0] SIZE_MAX   = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'((DEPTH < 1024) ? DEPTH : 1024);

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_PEEK  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      FILL_EMPTY  = 2'd0,
      FILL_NORMAL = 2'd1,
      FILL_FULL   = 2'd2
   } fill_type;

   typedef enum logic {
      MODE_LINEAR = 1'b0,
      MODE_RING   = 1'b1
   } mode_type;

   typedef enum logic {
      CSR_MODE = 1'b0,
      CSR_SIZE = 1'b1
   } csr_idx_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RESP = 1'b1
   } state_type;

   typedef struct packed {
      kind_type            kind;
      logic [DATA_W-1:0]   data_in;
      logic [OFF_W-1:0]    offset;
   } req_word_type;

   typedef struct packed {
      logic                accepted;
      logic [DATA_W-1:0]   data_out;
      logic [CNT_W-1:0]    readable;
      logic [CNT_W-1:0]    writable;
      fill_type            fill_state;
   } rsp_word_type;

   typedef struct packed {
      logic exec;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic                mode_we;
      logic                size_we;
      logic [PDATA_W-1:0]  wdata;
   } cfg_cmd_type;

endpackage

// ----- rtl/core/brlb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brlb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/brlb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlb_ctrl
// Sequencer: takes a word, waits in the response state for the registered
// store read data, then loads the result register when it is free.
// ----------------------------------------------------------------------------
module brlb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output brlb_pkg::dp_cmd_type  cmd
);

   brlb_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brlb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         brlb_pkg::ST_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.exec = 1'b1;
               state_in = brlb_pkg::ST_RESP;
            end
         end
         brlb_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load = 1'b1;
               state_in = brlb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brlb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/brlb_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlb_dpath
// Positions, occupancy, mode/size registers, store access and result register.
// ----------------------------------------------------------------------------
module brlb_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  brlb_pkg::dp_cmd_type              cmd,
   input  brlb_pkg::cfg_cmd_type             cfg,
   input  brlb_pkg::req_word_type            req_payload,
   output brlb_pkg::rsp_word_type            rsp_payload,
   output logic                              mode,
   output logic [brlb_pkg::CNT_W-1:0]        size
);

   localparam int CW = brlb_pkg::CNT_W;
   localparam int AW = brlb_pkg::ADDR_W;

   logic                        mode_ff, mode_in;
   logic [CW-1:0]               size_ff, size_in;
   logic [CW-1:0]               rp_ff, rp_in;
   logic [CW-1:0]               wp_ff, wp_in;
   brlb_pkg::fill_type          occ_ff, occ_in;
   logic                        acc_ff, acc_in;
   logic                        dsel_ff, dsel_in;
   brlb_pkg::rsp_word_type      rsp_ff, rsp_in;

   logic [CW-1:0]               readable_now, writable_now;
   logic [CW-1:0]               rp_inc, wp_inc, rp_wrap, wp_wrap, off_ext, size_clamp;
   logic [CW:0]                 peek_sum, peek_idx;
   logic                        ram_we, ram_re;
   logic [AW-1:0]               ram_addr;
   logic [brlb_pkg::DATA_W-1:0] ram_rdata;

   function automatic logic [CW-1:0] count_readable(
      input logic               m,
      input logic [CW-1:0]      s,
      input logic [CW-1:0]      r,
      input logic [CW-1:0]      w,
      input brlb_pkg::fill_type o
   );
      logic [CW-1:0] n;
      if (m == brlb_pkg::MODE_LINEAR) begin
         n = w - r;
      end else begin
         case (o)
            brlb_pkg::FILL_EMPTY: n = '0;
            brlb_pkg::FILL_FULL:  n = s;
            default: begin
               if (w > r) begin
                  n = w - r;
               end else begin
                  n = w + s - r;
               end
            end
         endcase
      end
      return n;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= brlb_pkg::MODE_RING;
         size_ff <= brlb_pkg::SIZE_RESET;
         rp_ff   <= '0;
         wp_ff   <= '0;
         occ_ff  <= brlb_pkg::FILL_EMPTY;
      end else begin
         mode_ff <= mode_in;
         size_ff <= size_in;
         rp_ff   <= rp_in;
         wp_ff   <= wp_in;
         occ_ff  <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      dsel_ff <= dsel_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      readable_now = count_readable(mode_ff, size_ff, rp_ff, wp_ff, occ_ff);
      if (mode_ff == brlb_pkg::MODE_LINEAR) begin
         writable_now = size_ff - wp_ff;
      end else begin
         writable_now = size_ff - readable_now;
      end
      rp_inc   = rp_ff + CW'(1);
      wp_inc   = wp_ff + CW'(1);
      rp_wrap  = (rp_inc >= size_ff) ? '0 : rp_inc;
      wp_wrap  = (wp_inc >= size_ff) ? '0 : wp_inc;
      off_ext  = CW'(req_payload.offset);
      peek_sum = {1'b0, rp_ff} + {1'b0, off_ext};
      peek_idx = (peek_sum >= {1'b0, size_ff}) ? peek_sum - {1'b0, size_ff} : peek_sum;
      size_clamp = cfg.wdata[CW-1:0];
      if (size_clamp == '0) begin
         size_clamp = CW'(1);
      end else if (size_clamp > brlb_pkg::SIZE_MAX) begin
         size_clamp = brlb_pkg::SIZE_MAX;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      size_in  = size_ff;
      rp_in    = rp_ff;
      wp_in    = wp_ff;
      occ_in   = occ_ff;
      acc_in   = acc_ff;
      dsel_in  = dsel_ff;
      ram_we   = 1'b0;
      ram_re   = 1'b0;
      ram_addr = wp_ff[AW-1:0];

      if (cmd.exec) begin
         acc_in  = 1'b0;
         dsel_in = 1'b0;
         case (req_payload.kind)
            brlb_pkg::KIND_WRITE: begin
               if (writable_now != '0) begin
                  ram_we   = 1'b1;
                  ram_addr = wp_ff[AW-1:0];
                  acc_in   = 1'b1;
                  if (mode_ff == brlb_pkg::MODE_LINEAR) begin
                     if (rp_ff == wp_inc) begin
                        rp_in  = '0;
                        wp_in  = '0;
                        occ_in = brlb_pkg::FILL_EMPTY;
                     end else begin
                        wp_in  = wp_inc;
                        occ_in = (wp_inc == size_ff) ? brlb_pkg::FILL_FULL
                                                     : brlb_pkg::FILL_NORMAL;
                     end
                  end else begin
                     wp_in  = wp_wrap;
                     occ_in = (rp_ff != wp_wrap) ? brlb_pkg::FILL_NORMAL
                                                 : brlb_pkg::FILL_FULL;
                  end
               end
            end
            brlb_pkg::KIND_READ: begin
               if (readable_now != '0) begin
                  ram_re   = 1'b1;
                  ram_addr = rp_ff[AW-1:0];
                  acc_in   = 1'b1;
                  dsel_in  = 1'b1;
                  if (mode_ff == brlb_pkg::MODE_LINEAR) begin
                     if (rp_inc == wp_ff) begin
                        rp_in  = '0;
                        wp_in  = '0;
                        occ_in = brlb_pkg::FILL_EMPTY;
                     end else begin
                        rp_in  = rp_inc;
                        occ_in = (wp_ff == size_ff) ? brlb_pkg::FILL_FULL
                                                    : brlb_pkg::FILL_NORMAL;
                     end
                  end else begin
                     rp_in  = rp_wrap;
                     occ_in = (rp_wrap != wp_ff) ? brlb_pkg::FILL_NORMAL
                                                 : brlb_pkg::FILL_EMPTY;
                  end
               end
            end
            brlb_pkg::KIND_PEEK: begin
               if (mode_ff == brlb_pkg::MODE_LINEAR) begin
                  if (off_ext >= rp_ff && off_ext < wp_ff) begin
                     ram_re   = 1'b1;
                     ram_addr = off_ext[AW-1:0];
                     acc_in   = 1'b1;
                     dsel_in  = 1'b1;
                  end
               end else if (off_ext < readable_now) begin
                  ram_re   = 1'b1;
                  ram_addr = peek_idx[AW-1:0];
                  acc_in   = 1'b1;
                  dsel_in  = 1'b1;
               end
            end
            default: begin
               rp_in  = '0;
               wp_in  = '0;
               occ_in = brlb_pkg::FILL_EMPTY;
            end
         endcase
      end

      if (cfg.mode_we) begin
         mode_in = cfg.wdata[0];
         rp_in   = '0;
         wp_in   = '0;
         occ_in  = brlb_pkg::FILL_EMPTY;
      end
      if (cfg.size_we) begin
         size_in = size_clamp;
         rp_in   = '0;
         wp_in   = '0;
         occ_in  = brlb_pkg::FILL_EMPTY;
      end
   end

   // state regs already hold the post-item values here
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load) begin
         rsp_in.accepted   = acc_ff;
         rsp_in.data_out   = dsel_ff ? ram_rdata : '0;
         rsp_in.readable   = readable_now;
         rsp_in.writable   = writable_now;
         rsp_in.fill_state = occ_ff;
      end
   end

   brlb_ram #(
      .WIDTH (brlb_pkg::DATA_W),
      .DEPTH (brlb_pkg::DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_addr),
      .wdata (req_payload.data_in),
      .re    (ram_re),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   assign rsp_payload = rsp_ff;
   assign mode        = mode_ff;
   assign size        = size_ff;

   a_ring_bounds: assert property (@(posedge clock) disable iff (reset)
      mode_ff == brlb_pkg::MODE_RING |-> rp_ff < size_ff && wp_ff < size_ff)
      else $error("ring position beyond size");

   a_linear_bounds: assert property (@(posedge clock) disable iff (reset)
      mode_ff == brlb_pkg::MODE_LINEAR |-> rp_ff <= wp_ff && wp_ff <= size_ff)
      else $error("linear positions out of order");

   a_ring_normal: assert property (@(posedge clock) disable iff (reset)
      mode_ff == brlb_pkg::MODE_RING && occ_ff == brlb_pkg::FILL_NORMAL |-> rp_ff != wp_ff)
      else $error("ring normal with equal positions");

   a_linear_empty: assert property (@(posedge clock) disable iff (reset)
      mode_ff == brlb_pkg::MODE_LINEAR && rp_ff == wp_ff |-> occ_ff == brlb_pkg::FILL_EMPTY)
      else $error("linear caught up but not empty");

   a_size_range: assert property (@(posedge clock) disable iff (reset)
      size_ff != '0 && size_ff <= brlb_pkg::SIZE_MAX)
      else $error("size out of range");

endmodule

// ----- rtl/core/byte_ring_or_linear_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_or_linear_buffer
// Byte FIFO store worked as a ring or linear buffer, with peek and clear.
// ----------------------------------------------------------------------------
// Each request word is taken in the accept cycle, where the positions are
// updated and the single-port byte store is written or read; then, once the
// response register is free, the registered store data is loaded into it. The
// next word is taken as soon as the response is loaded, even while it still
// waits on rsp_stall; a held response holds back the next load until it
// drains. The store is not swept at reset: a byte is only readable after it
// has been written, so the block is ready right out of reset. Registers:
// 0x0 buffer_mode (0 linear, 1 ring), 0x4 size_in_use (0 taken as 1,
// clamped to the store depth); writing either clears the positions.
// ----------------------------------------------------------------------------
module byte_ring_or_linear_buffer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  brlb_pkg::req_word_type            req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output brlb_pkg::rsp_word_type            rsp_payload,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [brlb_pkg::PADDR_W-1:0]      csr_paddr,
   input  logic [brlb_pkg::PDATA_W-1:0]      csr_pwdata,
   output logic [brlb_pkg::PDATA_W-1:0]      csr_prdata,
   output logic                              csr_pready
);

   brlb_pkg::dp_cmd_type           cmd;
   brlb_pkg::cfg_cmd_type          cfg;
   brlb_pkg::csr_idx_type          csr_idx;
   logic                           csr_wr;
   logic                           cur_mode;
   logic [brlb_pkg::CNT_W-1:0]     cur_size;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = brlb_pkg::csr_idx_type'(csr_paddr[2]);

   always_comb begin
      cfg         = '0;
      cfg.wdata   = csr_pwdata;
      csr_prdata  = '0;
      unique case (csr_idx)
         brlb_pkg::CSR_MODE: begin
            cfg.mode_we = csr_wr;
            csr_prdata  = brlb_pkg::PDATA_W'(cur_mode);
         end
         brlb_pkg::CSR_SIZE: begin
            cfg.size_we = csr_wr;
            csr_prdata  = brlb_pkg::PDATA_W'(cur_size);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   brlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   brlb_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .mode        (cur_mode),
      .size        (cur_size)
   );

endmodule

// ----- tb/sv/byte_ring_or_linear_buffer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_or_linear_buffer_tb
// Self-checking bench for the byte ring / linear buffer.
// ----------------------------------------------------------------------------
// Request words come from a queue and go out with random gaps. The response
// side stalls at random. An in-bench model of the positions, occupancy and
// byte store predicts each response word as its request is taken, and the
// monitor compares every field in order. Registers are set over the APB port
// between phases, with a read-back check. Phases cover directed corner cases,
// a fill of the full store with wrap, and mixed random traffic in both modes
// over a range of sizes.
// ----------------------------------------------------------------------------
module byte_ring_or_linear_buffer_tb;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_stall;
   brlb_pkg::req_word_type          req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_stall   = 1'b0;
   brlb_pkg::rsp_word_type          rsp_payload;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [brlb_pkg::PADDR_W-1:0]    csr_paddr   = '0;
   logic [brlb_pkg::PDATA_W-1:0]    csr_pwdata  = '0;
   logic [brlb_pkg::PDATA_W-1:0]    csr_prdata;
   logic                            csr_pready;

   byte_ring_or_linear_buffer uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // buffer model state
   logic [brlb_pkg::DATA_W-1:0]     byte_mem [brlb_pkg::DEPTH];
   brlb_pkg::mode_type              cur_mode;
   logic [brlb_pkg::CNT_W-1:0]      cur_size;
   logic [brlb_pkg::CNT_W-1:0]      rd_pos;
   logic [brlb_pkg::CNT_W-1:0]      wr_pos;
   brlb_pkg::fill_type              cur_fill;

   brlb_pkg::req_word_type          pending_words [$];
   brlb_pkg::rsp_word_type          due_results [$];
   brlb_pkg::rsp_word_type          rsp_due;
   int                              errors = 0;

   int                              req_accepts = 0;
   int                              req_seen    = 0;
   bit                              req_hold    = 1'b0;
   bit                              req_calm    = 1'b0;
   int                              req_gap     = 0;
   int                              rsp_accepts = 0;
   int                              rsp_seen    = 0;
   bit                              rsp_calm    = 1'b0;
   int                              rsp_wait    = 0;

   function automatic logic [brlb_pkg::CNT_W-1:0] readable_now();
      if (cur_mode == brlb_pkg::MODE_LINEAR) return wr_pos - rd_pos;
      if (cur_fill == brlb_pkg::FILL_EMPTY) return '0;
      if (cur_fill == brlb_pkg::FILL_FULL) return cur_size;
      return brlb_pkg::CNT_W'((int'(wr_pos) + int'(cur_size) - int'(rd_pos))
                              % int'(cur_size));
   endfunction

   function automatic logic [brlb_pkg::CNT_W-1:0] writable_now();
      if (cur_mode == brlb_pkg::MODE_LINEAR) return cur_size - wr_pos;
      return cur_size - readable_now();
   endfunction

   task automatic clear_positions();
      rd_pos   = '0;
      wr_pos   = '0;
      cur_fill = brlb_pkg::FILL_EMPTY;
   endtask

   task automatic settle_linear();
      if (rd_pos == wr_pos) clear_positions();
      else if (wr_pos == cur_size) cur_fill = brlb_pkg::FILL_FULL;
      else cur_fill = brlb_pkg::FILL_NORMAL;
   endtask

   task automatic buffer_predict(input brlb_pkg::req_word_type w);
      brlb_pkg::rsp_word_type r;
      r = '0;
      case (w.kind)
         brlb_pkg::KIND_WRITE: begin
            if (writable_now() != '0) begin
               byte_mem[wr_pos[brlb_pkg::ADDR_W-1:0]] = w.data_in;
               wr_pos     = wr_pos + brlb_pkg::CNT_W'(1);
               r.accepted = 1'b1;
               if (cur_mode == brlb_pkg::MODE_LINEAR) begin
                  settle_linear();
               end else begin
                  if (wr_pos >= cur_size) wr_pos = '0;
                  cur_fill = (rd_pos != wr_pos) ? brlb_pkg::FILL_NORMAL
                                                : brlb_pkg::FILL_FULL;
               end
            end
         end
         brlb_pkg::KIND_READ: begin
            if (readable_now() != '0) begin
               r.data_out = byte_mem[rd_pos[brlb_pkg::ADDR_W-1:0]];
               rd_pos     = rd_pos + brlb_pkg::CNT_W'(1);
               r.accepted = 1'b1;
               if (cur_mode == brlb_pkg::MODE_LINEAR) begin
                  settle_linear();
               end else begin
                  if (rd_pos >= cur_size) rd_pos = '0;
                  cur_fill = (rd_pos != wr_pos) ? brlb_pkg::FILL_NORMAL
                                                : brlb_pkg::FILL_EMPTY;
               end
            end
         end
         brlb_pkg::KIND_PEEK: begin
            if (cur_mode == brlb_pkg::MODE_LINEAR) begin
               if (brlb_pkg::CNT_W'(w.offset) >= rd_pos &&
                   brlb_pkg::CNT_W'(w.offset) < wr_pos) begin
                  r.accepted = 1'b1;
                  r.data_out = byte_mem[w.offset];
               end
            end else if (brlb_pkg::CNT_W'(w.offset) < readable_now()) begin
               r.accepted = 1'b1;
               r.data_out = byte_mem[brlb_pkg::ADDR_W'((int'(rd_pos) + int'(w.offset))
                                                       % int'(cur_size))];
            end
         end
         default: clear_positions();
      endcase
      r.readable   = readable_now();
      r.writable   = writable_now();
      r.fill_state = cur_fill;
      due_results.push_back(r);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // request acceptance feeds the model; response acceptance is checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            buffer_predict(req_payload);
            req_accepts++;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_accepts++;
            if (due_results.size() == 0) begin
               $display("%0t: unexpected response word, expected none, got %h",
                        $time, rsp_payload);
               errors++;
            end else begin
               rsp_due = due_results.pop_front();
               compare_field("accepted", 32'(rsp_due.accepted),
                             32'(rsp_payload.accepted));
               compare_field("data_out", 32'(rsp_due.data_out),
                             32'(rsp_payload.data_out));
               compare_field("readable", 32'(rsp_due.readable),
                             32'(rsp_payload.readable));
               compare_field("writable", 32'(rsp_due.writable),
                             32'(rsp_payload.writable));
               compare_field("fill_state", 32'(rsp_due.fill_state),
                             32'(rsp_payload.fill_state));
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_hold && req_accepts != req_seen) begin
            req_seen = req_accepts;
            req_hold = 1'b0;
            if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
            req_gap = req_calm ? 0 : $urandom_range(0, 16);
         end
         if (!req_hold) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_words.size() > 0) begin
               req_payload <= pending_words.pop_front();
               req_hold = 1'b1;
            end
         end
         req_valid <= req_hold;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_accepts != rsp_seen) begin
            rsp_seen = rsp_accepts;
            if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
            rsp_wait = rsp_calm ? 0 : $urandom_range(0, 16);
         end
         if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic csr_cycle(input bit wr, input brlb_pkg::csr_idx_type idx,
                            input logic [brlb_pkg::PDATA_W-1:0] wdata,
                            output logic [brlb_pkg::PDATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= brlb_pkg::PADDR_W'(4 * int'(idx));
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_csr(input brlb_pkg::csr_idx_type idx,
                          input logic [brlb_pkg::PDATA_W-1:0] value);
      logic [brlb_pkg::PDATA_W-1:0] rdata;
      logic [brlb_pkg::PDATA_W-1:0] want;
      logic [brlb_pkg::CNT_W-1:0]   sz;
      csr_cycle(1'b1, idx, value, rdata);
      if (idx == brlb_pkg::CSR_MODE) begin
         cur_mode = brlb_pkg::mode_type'(value[0]);
      end else begin
         sz = value[brlb_pkg::CNT_W-1:0];
         if (sz == '0) sz = brlb_pkg::CNT_W'(1);
         else if (sz > brlb_pkg::SIZE_MAX) sz = brlb_pkg::SIZE_MAX;
         cur_size = sz;
      end
      clear_positions();
      want = (idx == brlb_pkg::CSR_MODE) ? brlb_pkg::PDATA_W'(cur_mode)
                                         : brlb_pkg::PDATA_W'(cur_size);
      csr_cycle(1'b0, idx, '0, rdata);
      if (rdata !== want) begin
         $display("%0t: register %0d read back, expected %0d, got %0d",
                  $time, idx, want, rdata);
         errors++;
      end
   endtask

   task automatic add_word(input brlb_pkg::kind_type k, input int unsigned d,
                           input int unsigned o);
      pending_words.push_back(brlb_pkg::req_word_type'{kind: k,
                                                       data_in: brlb_pkg::DATA_W'(d),
                                                       offset: brlb_pkg::OFF_W'(o)});
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_words.size() != 0 || req_hold || due_results.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // runs of filling and draining, with peeks mostly near the readable range
   task automatic queue_mixed(input int count);
      int                  r;
      bit                  filling;
      brlb_pkg::kind_type  k;
      filling = 1'b1;
      repeat (count) begin
         if ($urandom_range(0, 11) == 0) filling = !filling;
         r = $urandom_range(0, 99);
         if (r < 2) k = brlb_pkg::KIND_CLEAR;
         else if (r < 22) k = brlb_pkg::KIND_PEEK;
         else if (r < (filling ? 82 : 42)) k = brlb_pkg::KIND_WRITE;
         else k = brlb_pkg::KIND_READ;
         add_word(k, $urandom, ($urandom_range(0, 9) == 0) ? $urandom
                                 : $urandom_range(0, int'(cur_size) + 1));
      end
   endtask

   task automatic run_phase(input brlb_pkg::mode_type m, input int unsigned sz,
                            input int count);
      set_csr(brlb_pkg::CSR_MODE, brlb_pkg::PDATA_W'(m));
      set_csr(brlb_pkg::CSR_SIZE, brlb_pkg::PDATA_W'(sz));
      queue_mixed(count);
      wait_drained();
   endtask

   initial begin
      foreach (byte_mem[i]) byte_mem[i] = '0;
      cur_mode = brlb_pkg::MODE_RING;
      cur_size = brlb_pkg::SIZE_RESET;
      clear_positions();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: ring of full depth
      add_word(brlb_pkg::KIND_READ, 0, 0);
      add_word(brlb_pkg::KIND_PEEK, 0, 0);
      add_word(brlb_pkg::KIND_WRITE, 'h00, 0);
      add_word(brlb_pkg::KIND_WRITE, 'hFF, 0);
      add_word(brlb_pkg::KIND_PEEK, 0, 1);
      add_word(brlb_pkg::KIND_PEEK, 0, 1023);
      add_word(brlb_pkg::KIND_READ, 0, 0);
      add_word(brlb_pkg::KIND_CLEAR, 0, 0);
      add_word(brlb_pkg::KIND_READ, 0, 0);
      wait_drained();

      // linear: full stays full after reads, catch-up resets positions
      set_csr(brlb_pkg::CSR_MODE, brlb_pkg::PDATA_W'(brlb_pkg::MODE_LINEAR));
      set_csr(brlb_pkg::CSR_SIZE, 3);
      add_word(brlb_pkg::KIND_WRITE, 'hA5, 0);
      add_word(brlb_pkg::KIND_WRITE, 'h5A, 0);
      add_word(brlb_pkg::KIND_WRITE, 'hFF, 0);
      add_word(brlb_pkg::KIND_WRITE, 'h01, 0);
      add_word(brlb_pkg::KIND_READ, 0, 0);
      add_word(brlb_pkg::KIND_PEEK, 0, 0);
      add_word(brlb_pkg::KIND_PEEK, 0, 2);
      add_word(brlb_pkg::KIND_WRITE, 'h02, 0);
      add_word(brlb_pkg::KIND_READ, 0, 0);
      add_word(brlb_pkg::KIND_READ, 0, 0);
      add_word(brlb_pkg::KIND_WRITE, 'h3C, 0);
      wait_drained();

      // size 0 taken as 1
      set_csr(brlb_pkg::CSR_MODE, brlb_pkg::PDATA_W'(brlb_pkg::MODE_RING));
      set_csr(brlb_pkg::CSR_SIZE, 0);
      add_word(brlb_pkg::KIND_WRITE, 'h81, 0);
      add_word(brlb_pkg::KIND_WRITE, 'h7E, 0);
      add_word(brlb_pkg::KIND_PEEK, 0, 0);
      add_word(brlb_pkg::KIND_READ, 0, 0);
      add_word(brlb_pkg::KIND_PEEK, 0, 0);
      wait_drained();

      // oversize clamped to depth; fill to full, then wrap
      set_csr(brlb_pkg::CSR_SIZE, 2047);
      repeat (1026) add_word(brlb_pkg::KIND_WRITE, $urandom, 0);
      add_word(brlb_pkg::KIND_PEEK, 0, 1023);
      add_word(brlb_pkg::KIND_PEEK, 0, 0);
      repeat (5) add_word(brlb_pkg::KIND_READ, 0, 0);
      repeat (6) add_word(brlb_pkg::KIND_WRITE, $urandom, 0);
      add_word(brlb_pkg::KIND_PEEK, 0, 1023);
      add_word(brlb_pkg::KIND_READ, 0, 0);
      wait_drained();

      run_phase(brlb_pkg::MODE_LINEAR, 1024, 30);
      run_phase(brlb_pkg::MODE_LINEAR, 1, 30);
      run_phase(brlb_pkg::MODE_RING, 1, 30);
      run_phase(brlb_pkg::MODE_RING, 2, 30);
      run_phase(brlb_pkg::MODE_LINEAR, 2, 30);
      run_phase(brlb_pkg::MODE_RING, 5, 30);
      run_phase(brlb_pkg::MODE_LINEAR, 8, 30);
      run_phase(brlb_pkg::MODE_RING, 13, 30);
      run_phase(brlb_pkg::MODE_LINEAR, 31, 40);
      run_phase(brlb_pkg::MODE_RING, 64, 40);
      repeat (5) run_phase(brlb_pkg::mode_type'($urandom_range(0, 1)),
                           $urandom_range(1, 40), 30);

      if (errors == 0) begin
         $display("byte_ring_or_linear_buffer_tb: clean");
      end else begin
         $display("byte_ring_or_linear_buffer_tb: errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("byte_ring_or_linear_buffer_tb: errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/brlb_pkg.sv
rtl/core/brlb_ram.sv
rtl/core/brlb_ctrl.sv
rtl/core/brlb_dpath.sv
rtl/core/byte_ring_or_linear_buffer.sv
tb/sv/byte_ring_or_linear_buffer_tb.sv
